// ===== rtl/krum_pkg.sv =====
// ============================================================================
// krum_pkg
// Shared types and constants for the k-mer to unitig matcher.
// ============================================================================
package krum_pkg;

    // Controller states, one-hot
    typedef enum logic [19:0] {
        S_CLEAR   = 20'h00001,
        S_IDLE    = 20'h00002,
        S_H0      = 20'h00004,
        S_H1      = 20'h00008,
        S_H2      = 20'h00010,
        S_H3      = 20'h00020,
        S_PRB_RD  = 20'h00040,
        S_PRB_CHK = 20'h00080,
        S_IEMIT   = 20'h00100,
        S_SCAN    = 20'h00200,
        S_LOAD    = 20'h00400,
        S_LDAT    = 20'h00800,
        S_WIN     = 20'h01000,
        S_MATCH   = 20'h02000,
        S_PUT     = 20'h04000,
        S_LEN_RD  = 20'h08000,
        S_LEN_DAT = 20'h10000,
        S_JCHK    = 20'h20000,
        S_FIN1    = 20'h40000,
        S_FIN2    = 20'h80000
    } t_state;

    // Signed position / offset arithmetic
    typedef logic signed [23:0] t_sval;

    // Item kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_BASE   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    // Stored code of an N base
    localparam logic [2:0] BASE_N = 3'd4;

    // Hash multiplier halves
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;

    // Linear probing run length
    localparam int PROBE_LIMIT = 127;

    // Results per read
    localparam logic [6:0] MAX_RESULTS = 7'd64;

    // Table word: valid, key, info
    localparam int INFO_W  = 37;
    localparam int TWORD_W = 1 + 64 + INFO_W;

    // Mask of the low 2*k bits
    function automatic logic [63:0] kmer_mask(input logic [5:0] k);
        logic [63:0] m;
        if (k >= 6'd32) begin
            m = '1;
        end else begin
            m = (64'd1 << {k, 1'b0}) - 64'd1;
        end
        return m;
    endfunction

endpackage

// ===== rtl/krum_ram.sv =====
// ============================================================================
// krum_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module krum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kmer_read_to_unitig_matcher_core.sv =====
// Insert: hash states S_H0 to S_H3, then S_PRB_RD and S_PRB_CHK per probed slot, then S_IEMIT.
// Read end: per window, S_LOAD and S_LDAT for each newly loaded base, then the hash and probe;
//   a hit adds S_MATCH, S_PUT when an interval opens, S_LEN_RD and S_LEN_DAT, or S_JCHK on a jump probe.
// Throughput: one item per cycle for plain bases, otherwise sequential.
// Reset: clears control state, then sweeps the k-mer table valid bits
//   one entry at a time, with no item accepted during the sweep.
// ============================================================================
// kmer_read_to_unitig_matcher_core
// Hashed k-mer table, unitig length table and read scanner that reports
// match intervals of a read against unitigs.
// ============================================================================
module kmer_read_to_unitig_matcher_core
    import krum_pkg::*;
#(
    parameter int TABLE_ENTRIES = 65536,
    parameter int UNITIG_COUNT  = 65536,
    parameter int READ_MAX      = 64,
    parameter int KMER_MAX      = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [63:0]        i_kmer_key,
    input  logic [15:0]        i_unitig_id,
    input  logic [19:0]        i_unitig_position,
    input  logic               i_kmer_reversed,
    input  logic [19:0]        i_unitig_len,
    input  logic [2:0]         i_base_code,
    input  logic               i_read_end,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_match_unitig,
    output logic signed [21:0] o_overhang,
    output logic               o_match_reverse,
    output logic               o_final_result
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int LW    = $clog2(UNITIG_COUNT);
    localparam int RA    = $clog2(READ_MAX);
    localparam int CW    = $clog2(READ_MAX + 1);
    localparam int PSPAN = (TABLE_ENTRIES < PROBE_LIMIT) ? TABLE_ENTRIES : PROBE_LIMIT;

    t_state r_state;

    logic [AW-1:0]     r_clr;
    logic [5:0]        r_kmer_len;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_len_rd;
    logic [63:0]       r_key;
    logic [INFO_W-1:0] r_info;
    logic              r_ins;
    logic [AW-1:0]     r_slot;
    logic [7:0]        r_pn;
    logic [1:0]        r_st;
    logic [63:0]       r_p0;
    logic [31:0]       r_x;
    logic [63:0]       r_fwd;
    logic [63:0]       r_rc;
    logic              r_cori;
    logic [CW-1:0]     r_p;
    logic [CW-1:0]     r_lastn;
    logic [CW-1:0]     r_w;
    logic              r_jmode;
    logic [CW-1:0]     r_j;
    t_sval             r_iend;
    logic              r_have;
    logic [15:0]       r_hold_u;
    t_sval             r_hold_off;
    logic              r_hold_ori;
    t_sval             r_ahg;
    logic [6:0]        r_n;
    logic              r_pend_v;
    logic [15:0]       r_pend_u;
    logic [21:0]       r_pend_ahg;
    logic              r_pend_ori;
    logic [15:0]       r_m_u;
    t_sval             r_m_first;
    logic              r_m_net;
    logic              r_opened;
    logic [INFO_W-1:0] r_hinfo;

    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [15:0]       r_o_unitig;
    logic [21:0]       r_o_ahg;
    logic              r_o_rev;
    logic              r_o_final;

    // Memory ports
    logic               tb_we;
    logic [AW-1:0]      tb_waddr;
    logic [TWORD_W-1:0] tb_wdata;
    logic [TWORD_W-1:0] tb_rdata;
    logic               ln_we;
    logic [19:0]        ln_rdata;
    logic               rb_we;
    logic [2:0]         rb_wdata;
    logic [2:0]         rb_rdata;

    logic        w_accept;
    logic [5:0]  w_k;
    logic [63:0] w_mask;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_h;
    logic [63:0] w_hx;
    logic        w_out_free;
    logic [7:0]  w_p8;
    logic [7:0]  w_wk8;
    logic [1:0]  w_b2;
    logic [6:0]  w_sh;
    logic [63:0] w_fwd_n;
    logic [63:0] w_rc_n;
    logic        w_clean;
    logic        w_slot_valid;
    logic [63:0] w_slot_key;
    t_sval       w_ks;
    t_sval       w_ls;
    t_sval       w_ws;
    t_sval       w_js;
    t_sval       w_off;
    logic        w_net;
    t_sval       w_first;
    logic        w_opened;
    t_sval       w_len;
    t_sval       w_ahg_n;
    t_sval       w_bhg;
    t_sval       w_lastr;
    t_sval       w_jt;
    logic        w_jump;
    logic        w_need_put;
    logic        w_scan_done;
    logic        w_jmatch;

    // Clamp the k-mer length register
    always_comb begin
        if (r_kmer_len == 6'd0) begin
            w_k = 6'd1;
        end else if (r_kmer_len > 6'(KMER_MAX)) begin
            w_k = 6'(KMER_MAX);
        end else begin
            w_k = r_kmer_len;
        end
    end

    assign w_mask     = kmer_mask(w_k);
    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;

    // Shared 32x32 multiplier for the key hash
    assign w_ma   = (r_state == S_H2) ? r_key[63:32] : r_key[31:0];
    assign w_mb   = (r_state == S_H1) ? HASH_MUL_HI : HASH_MUL_LO;
    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_h    = {r_p0[63:32] + r_x, r_p0[31:0]};
    assign w_hx   = w_h ^ (w_h >> 29);

    // Rolling window update from one read buffer base
    assign w_p8    = {1'b0, r_p};
    assign w_wk8   = 8'(r_w) + 8'(w_k);
    assign w_b2    = rb_rdata[1:0];
    assign w_sh    = 7'({w_k, 1'b0}) - 7'd2;
    assign w_fwd_n = ((r_fwd << 2) | 64'(w_b2)) & w_mask;
    assign w_rc_n  = (r_rc >> 2) | (64'(2'd3 - w_b2) << w_sh);
    assign w_clean = (r_lastn <= r_w);

    assign w_slot_valid = tb_rdata[TWORD_W-1];
    assign w_slot_key   = tb_rdata[TWORD_W-2:INFO_W];

    // Window match arithmetic
    assign w_ks    = t_sval'(w_k);
    assign w_ls    = t_sval'(r_len_rd);
    assign w_ws    = t_sval'(r_w);
    assign w_js    = t_sval'(r_j);
    assign w_off   = t_sval'(r_hinfo[35:16]);
    assign w_net   = (r_hinfo[36] != r_cori);
    assign w_first = w_net ? (w_off + w_ws + w_ks) : (w_off - w_ws);
    assign w_opened = !r_have || (w_first != r_hold_off) || (r_hinfo[15:0] != r_hold_u)
                      || (w_net != r_hold_ori) || (w_js > r_iend);
    assign w_jmatch = (w_first == r_hold_off) && (r_hinfo[15:0] == r_hold_u)
                      && (w_net == r_hold_ori);

    // Overhangs and predicted last window
    always_comb begin
        w_len = (32'(r_m_u) < 32'(UNITIG_COUNT)) ? t_sval'(ln_rdata) : t_sval'(0);
        w_bhg = r_m_first + w_ls - w_len;
        if (!r_m_net) begin
            w_ahg_n = r_m_first;
            w_lastr = (w_bhg >= 0) ? (w_ls - w_bhg) : w_ls;
        end else begin
            w_ahg_n = r_m_first - w_ls;
            w_lastr = (w_ahg_n >= 0) ? w_ls : (w_ls + w_ahg_n);
        end
        w_jt   = w_lastr - w_ks;
        w_jump = r_opened && (w_jt > w_js) && (w_jt + w_ks <= w_ls);
    end

    assign w_need_put  = r_have && (r_n < MAX_RESULTS);
    assign w_scan_done = (8'(r_j) + 8'(w_k)) > 8'(r_len_rd);

    // Memory write controls
    assign tb_we    = (r_state == S_CLEAR) ||
                      ((r_state == S_PRB_CHK) && r_ins && !w_slot_valid);
    assign tb_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign tb_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, r_key, r_info};
    assign ln_we    = w_accept && (i_kind == KIND_LENGTH)
                      && (32'(i_unitig_id) < 32'(UNITIG_COUNT));
    assign rb_we    = w_accept && (i_kind == KIND_BASE) && (r_cnt < CW'(READ_MAX));
    assign rb_wdata = (i_base_code >= BASE_N) ? BASE_N : i_base_code;

    krum_ram #(.WIDTH(TWORD_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (tb_waddr),
        .i_wdata (tb_wdata),
        .i_raddr (r_slot),
        .o_rdata (tb_rdata)
    );

    krum_ram #(.WIDTH(20), .DEPTH(UNITIG_COUNT)) u_length (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (LW'(i_unitig_id)),
        .i_wdata (i_unitig_len),
        .i_raddr (LW'(r_m_u)),
        .o_rdata (ln_rdata)
    );

    krum_ram #(.WIDTH(3), .DEPTH(READ_MAX)) u_readbuf (
        .i_clk   (i_clk),
        .i_we    (rb_we),
        .i_waddr (r_cnt[RA-1:0]),
        .i_wdata (rb_wdata),
        .i_raddr (r_p[RA-1:0]),
        .o_rdata (rb_rdata)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= 6'd31;
        end else if (i_cfg_we) begin
            r_kmer_len <= i_cfg_wdata;
        end
    end

    // Output register: drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_IEMIT || r_state == S_FIN2) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if ((r_state == S_PUT || r_state == S_FIN1) && w_need_put
                     && r_pend_v && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IEMIT && w_out_free) begin
            r_o_status <= r_st;
            r_o_unitig <= '0;
            r_o_ahg    <= '0;
            r_o_rev    <= 1'b0;
            r_o_final  <= 1'b1;
        end else if (r_state == S_FIN2 && w_out_free) begin
            r_o_status <= r_pend_v ? ST_OK : ST_NOMATCH;
            r_o_unitig <= r_pend_v ? r_pend_u : 16'd0;
            r_o_ahg    <= r_pend_v ? r_pend_ahg : 22'd0;
            r_o_rev    <= r_pend_v && r_pend_ori;
            r_o_final  <= 1'b1;
        end else if ((r_state == S_PUT || r_state == S_FIN1) && w_need_put
                     && r_pend_v && w_out_free) begin
            r_o_status <= ST_OK;
            r_o_unitig <= r_pend_u;
            r_o_ahg    <= r_pend_ahg;
            r_o_rev    <= r_pend_ori;
            r_o_final  <= 1'b0;
        end
    end

    // Main controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_have   <= 1'b0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
        end else begin
            unique case (r_state)
                // Sweep table valid bits
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // Take an item
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_kind == KIND_INSERT) begin
                            r_key   <= i_kmer_key & w_mask;
                            r_info  <= {i_kmer_reversed, i_unitig_position, i_unitig_id};
                            r_ins   <= 1'b1;
                            r_state <= S_H0;
                        end else if (i_kind == KIND_BASE) begin
                            if (r_cnt < CW'(READ_MAX)) begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                            if (i_read_end) begin
                                r_len_rd   <= (r_cnt < CW'(READ_MAX)) ? r_cnt + CW'(1) : r_cnt;
                                r_j        <= '0;
                                r_p        <= '0;
                                r_lastn    <= '0;
                                r_fwd      <= '0;
                                r_rc       <= '0;
                                r_iend     <= '0;
                                r_ahg      <= '0;
                                r_hold_off <= '0;
                                r_hold_u   <= '0;
                                r_hold_ori <= 1'b0;
                                r_have     <= 1'b0;
                                r_pend_v   <= 1'b0;
                                r_n        <= '0;
                                r_ins      <= 1'b0;
                                r_state    <= S_SCAN;
                            end
                        end
                    end
                end
                // Hash: three partial products, then fold
                S_H0: begin
                    r_p0    <= w_prod;
                    r_state <= S_H1;
                end
                S_H1: begin
                    r_x     <= w_prod[31:0];
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_x     <= r_x + w_prod[31:0];
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_slot  <= w_hx[AW-1:0];
                    r_pn    <= '0;
                    r_state <= S_PRB_RD;
                end
                S_PRB_RD: begin
                    r_state <= S_PRB_CHK;
                end
                // Compare one slot of the probe run
                S_PRB_CHK: begin
                    if (!w_slot_valid) begin
                        if (r_ins) begin
                            r_st    <= ST_OK;
                            r_state <= S_IEMIT;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_SCAN;
                        end
                    end else if (w_slot_key == r_key) begin
                        if (r_ins) begin
                            r_st    <= ST_DUP;
                            r_state <= S_IEMIT;
                        end else begin
                            r_hinfo <= tb_rdata[INFO_W-1:0];
                            r_state <= r_jmode ? S_JCHK : S_MATCH;
                        end
                    end else if (r_pn + 8'd1 == 8'(PSPAN)) begin
                        if (r_ins) begin
                            r_st    <= ST_FULL;
                            r_state <= S_IEMIT;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_pn    <= r_pn + 8'd1;
                        r_slot  <= r_slot + AW'(1);
                        r_state <= S_PRB_RD;
                    end
                end
                S_IEMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                // Next window or finish
                S_SCAN: begin
                    if (w_scan_done) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_w     <= r_j;
                        r_jmode <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                // Bring the rolling window up to the target window
                S_LOAD: begin
                    if (w_p8 > w_wk8) begin
                        r_p     <= r_w;
                        r_lastn <= '0;
                    end else if (r_p < r_w) begin
                        r_p <= r_w;
                    end else if (w_p8 == w_wk8) begin
                        r_state <= S_WIN;
                    end else begin
                        r_state <= S_LDAT;
                    end
                end
                S_LDAT: begin
                    r_fwd <= w_fwd_n;
                    r_rc  <= w_rc_n;
                    if (rb_rdata >= BASE_N) begin
                        r_lastn <= r_p + CW'(1);
                    end
                    r_p     <= r_p + CW'(1);
                    r_state <= S_LOAD;
                end
                // Canonical key of a clean window
                S_WIN: begin
                    if (!w_clean) begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_key   <= (r_fwd < r_rc) ? r_fwd : r_rc;
                        r_cori  <= !(r_fwd < r_rc);
                        r_state <= S_H0;
                    end
                end
                S_MATCH: begin
                    r_m_u     <= r_hinfo[15:0];
                    r_m_first <= w_first;
                    r_m_net   <= w_net;
                    r_opened  <= w_opened;
                    r_iend    <= w_js + w_ks;
                    r_state   <= w_opened ? S_PUT : S_LEN_RD;
                end
                // Close the held interval, open the new one
                S_PUT: begin
                    if (!(w_need_put && r_pend_v && !w_out_free)) begin
                        if (w_need_put) begin
                            r_pend_v   <= 1'b1;
                            r_pend_u   <= r_hold_u;
                            r_pend_ahg <= r_ahg[21:0];
                            r_pend_ori <= r_hold_ori;
                            r_n        <= r_n + 7'd1;
                        end
                        r_hold_u   <= r_m_u;
                        r_hold_off <= r_m_first;
                        r_hold_ori <= r_m_net;
                        r_have     <= 1'b1;
                        r_state    <= S_LEN_RD;
                    end
                end
                S_LEN_RD: begin
                    r_state <= S_LEN_DAT;
                end
                // Overhang update and jump-ahead probe
                S_LEN_DAT: begin
                    r_ahg <= w_ahg_n;
                    if (w_jump) begin
                        r_w     <= CW'(w_jt);
                        r_jmode <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_JCHK: begin
                    if (w_jmatch) begin
                        r_j    <= r_w + CW'(1);
                        r_iend <= w_ws + w_ks;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                    r_state <= S_SCAN;
                end
                // Close the last interval
                S_FIN1: begin
                    if (!(w_need_put && r_pend_v && !w_out_free)) begin
                        if (w_need_put) begin
                            r_pend_v   <= 1'b1;
                            r_pend_u   <= r_hold_u;
                            r_pend_ahg <= r_ahg[21:0];
                            r_pend_ori <= r_hold_ori;
                            r_n        <= r_n + 7'd1;
                        end
                        r_state <= S_FIN2;
                    end
                end
                S_FIN2: begin
                    if (w_out_free) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_match_unitig  = r_o_unitig;
    assign o_overhang      = $signed(r_o_ahg);
    assign o_match_reverse = r_o_rev;
    assign o_final_result  = r_o_final;

endmodule
